[src/lagged_fibonacci_range_rng_defines.svh]
`ifndef LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH
`define LAGGED_FIBONACCI_RANGE_RNG_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LFR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LFR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lfr_pkg.sv]
`default_nettype none

package lfr_pkg;

  localparam int TABLE_DEPTH   = 55;
  localparam int PTR_BITS      = $clog2(TABLE_DEPTH);
  localparam int LAG_START     = TABLE_DEPTH - 24;
  localparam int OUT_SHIFT     = 6;
  localparam int WORD_BITS_DEF = 30;

  localparam int SEED_BITS  = 30;
  localparam int SEED_RESET = 1;

  localparam int OP_BITS    = 2;
  localparam int WIDTH_BITS = 5;
  localparam int RANGE_BITS = 24;
  localparam int COUNT_BITS = 8;
  localparam int SIDES_BITS = 16;
  localparam int VALUE_BITS = 25;
  localparam int SPAN_BITS  = 26;
  localparam int MASK_BITS  = 24;

  localparam logic [OP_BITS-1:0] OP_RAW    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RANGE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DICE   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_RESEED = 2'd3;

  typedef struct packed {
    logic accept;
    logic setup;
    logic fill_step;
    logic sum_step;
    logic eval_step;
    logic load_out;
    logic fill_seed_one;
  } lfr_cmd_t;

  typedef struct packed {
    logic in_reseed;
    logic nodraw;
    logic fill_last;
    logic eval_last;
  } lfr_sts_t;

  // All ones from the top set bit down: next power of two minus one.
  function automatic logic [MASK_BITS-1:0] smear(input logic [MASK_BITS-1:0] v);
    logic [MASK_BITS-1:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage

`default_nettype wire

[src/lfr_if.sv]
`default_nettype none

interface lfr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [lfr_pkg::OP_BITS-1:0]      opcode;
  logic        [lfr_pkg::WIDTH_BITS-1:0]   bit_width;
  logic signed [lfr_pkg::RANGE_BITS-1:0]   range_low;
  logic signed [lfr_pkg::RANGE_BITS-1:0]   range_high;
  logic        [lfr_pkg::COUNT_BITS-1:0]   dice_count;
  logic        [lfr_pkg::SIDES_BITS-1:0]   dice_sides;

  modport source (output valid, opcode, bit_width, range_low, range_high, dice_count,
                  dice_sides, input ready);
  modport sink (input valid, opcode, bit_width, range_low, range_high, dice_count,
                dice_sides, output ready);
endinterface

interface lfr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lfr_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface lfr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfr_pkg::SEED_BITS-1:0]  seed;

  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

`default_nettype wire

[src/lfr_ram.sv]
`default_nettype none

module lfr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[src/lfr_ctrl.sv]
`default_nettype none

`include "lagged_fibonacci_range_rng_defines.svh"

module lfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lfr_pkg::lfr_sts_t sts,
  output lfr_pkg::lfr_cmd_t      cmd
);

  import lfr_pkg::*;

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       reply;       // fill was asked for by a reseed item, so it answers
  logic       reply_next;
  logic       finish;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd               = '0;
    cmd.fill_seed_one = !reply;
    state_next        = state;
    reply_next        = reply;
    finish            = 1'b0;
    case (state)
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          if (reply) begin
            finish = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_reseed) begin
            state_next = S_FILL;
            reply_next = 1'b1;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.nodraw) begin
          finish = 1'b1;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_step = 1'b1;
        if (sts.eval_last) begin
          finish = 1'b1;
        end else begin
          state_next = S_SUM;
        end
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      if (out_free) begin
        cmd.load_out = 1'b1;
        state_next   = S_IDLE;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LFR_ASSERT_NXT(a_reseed_fills, clk, rst, (state == S_IDLE) && in_valid && sts.in_reseed, (state == S_FILL) && reply, "reseed item did not start an answering fill")
  `LFR_ASSERT_IMP(a_out_from_load, clk, rst, $rose(out_valid), $past(cmd.load_out), "result appeared without a load")

endmodule

`default_nettype wire

[src/lfr_dpath.sv]
`default_nettype none

`include "lagged_fibonacci_range_rng_defines.svh"

module lfr_dpath #(
  parameter int WORD_BITS = lfr_pkg::WORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lfr_pkg::lfr_cmd_t                     cmd,
  output lfr_pkg::lfr_sts_t                          sts,
  input  wire logic        [lfr_pkg::OP_BITS-1:0]    in_opcode,
  input  wire logic        [lfr_pkg::WIDTH_BITS-1:0] in_bit_width,
  input  wire logic signed [lfr_pkg::RANGE_BITS-1:0] in_range_low,
  input  wire logic signed [lfr_pkg::RANGE_BITS-1:0] in_range_high,
  input  wire logic        [lfr_pkg::COUNT_BITS-1:0] in_dice_count,
  input  wire logic        [lfr_pkg::SIDES_BITS-1:0] in_dice_sides,
  input  wire logic                                  cfg_we,
  input  wire logic        [lfr_pkg::SEED_BITS-1:0]  cfg_seed,
  output logic signed      [lfr_pkg::VALUE_BITS-1:0] out_value
);

  import lfr_pkg::*;

  localparam int DRAW_BITS = WORD_BITS - OUT_SHIFT;
  localparam int PW        = PTR_BITS + 1;

  logic [SEED_BITS-1:0] seed;
  logic [PTR_BITS-1:0]  wp;
  logic [PTR_BITS-1:0]  lp;
  logic [PTR_BITS-1:0]  fi;
  logic [WORD_BITS-1:0] f1;
  logic [WORD_BITS-1:0] f2;

  logic [OP_BITS-1:0]          op;
  logic [WIDTH_BITS-1:0]       width;
  logic [COUNT_BITS-1:0]       count;
  logic signed [SPAN_BITS-1:0] spm1;  // span minus one
  logic [VALUE_BITS-1:0]       mask;
  logic [VALUE_BITS-1:0]       acc;
  logic [VALUE_BITS-1:0]       acc_next;
  logic [COUNT_BITS-1:0]       left;
  logic [COUNT_BITS-1:0]       left_setup;
  logic [DRAW_BITS-1:0]        draw;

  logic                  ram_we;
  logic [PTR_BITS-1:0]   ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  rd_w;
  logic [WORD_BITS-1:0]  rd_l;
  logic [WORD_BITS-1:0]  sum;
  logic [WORD_BITS-1:0]  fill_word;
  logic [VALUE_BITS-1:0] n;
  logic                  hit;
  logic                  span_pos;
  logic [VALUE_BITS-1:0] acc_accept;
  logic [VALUE_BITS-1:0] mask_setup;

  lfr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (wp),
    .raddr_b (lp),
    .rdata_a (rd_w),
    .rdata_b (rd_l)
  );

  assign sum = rd_w + rd_l;

  always_comb begin
    if (fi == '0) begin
      fill_word = cmd.fill_seed_one ? WORD_BITS'(SEED_RESET) : WORD_BITS'(seed);
    end else if (fi == PTR_BITS'(1)) begin
      fill_word = WORD_BITS'(1);
    end else begin
      fill_word = f1 + f2;
    end
  end

  assign ram_we    = cmd.fill_step || cmd.sum_step;
  assign ram_waddr = cmd.fill_step ? fi : wp;
  assign ram_wdata = cmd.fill_step ? fill_word : sum;

  // Accept-time start value of the accumulator.
  always_comb begin
    case (in_opcode)
      OP_RANGE: acc_accept = VALUE_BITS'(in_range_low);
      OP_DICE:  acc_accept = (in_dice_sides == '0) ? '0 : VALUE_BITS'(in_dice_count);
      default:  acc_accept = '0;
    endcase
  end

  // Setup: number of accepted draws still owed, and the draw mask.
  assign span_pos = !spm1[SPAN_BITS-1] && (spm1 != '0);

  always_comb begin
    case (op)
      OP_RAW:   left_setup = COUNT_BITS'(1);
      OP_RANGE: left_setup = span_pos ? COUNT_BITS'(1) : '0;
      OP_DICE:  left_setup = span_pos ? count : '0;
      default:  left_setup = '0;
    endcase
    if (op == OP_RAW) begin
      if (width >= WIDTH_BITS'(VALUE_BITS)) begin
        mask_setup = '1;
      end else begin
        mask_setup = (VALUE_BITS'(1) << width) - VALUE_BITS'(1);
      end
    end else begin
      mask_setup = VALUE_BITS'(smear(spm1[MASK_BITS-1:0]));
    end
  end

  assign n   = VALUE_BITS'(draw) & mask;
  assign hit = (op == OP_RAW) || (n <= spm1[VALUE_BITS-1:0]);

  always_comb begin
    acc_next = acc;
    if (cmd.eval_step && hit) begin
      acc_next = acc + n;
    end
  end

  assign sts.in_reseed = (in_opcode == OP_RESEED);
  assign sts.nodraw    = (left_setup == '0);
  assign sts.fill_last = (fi == PTR_BITS'(TABLE_DEPTH - 1));
  assign sts.eval_last = hit && (left == COUNT_BITS'(1));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_BITS'(SEED_RESET);
      wp   <= '0;
      lp   <= PTR_BITS'(LAG_START);
      fi   <= '0;
      left <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_seed;
      end
      if (cmd.accept && sts.in_reseed) begin
        wp <= '0;
        lp <= PTR_BITS'(LAG_START);
        fi <= '0;
      end else if (cmd.sum_step) begin
        wp <= (wp == PTR_BITS'(TABLE_DEPTH - 1)) ? '0 : wp + PTR_BITS'(1);
        lp <= (lp == PTR_BITS'(TABLE_DEPTH - 1)) ? '0 : lp + PTR_BITS'(1);
      end
      if (cmd.fill_step && !sts.fill_last) begin
        fi <= fi + PTR_BITS'(1);
      end
      if (cmd.setup) begin
        left <= left_setup;
      end else if (cmd.eval_step && hit) begin
        left <= left - COUNT_BITS'(1);
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      f2 <= f1;
      f1 <= fill_word;
    end
    if (cmd.accept) begin
      op    <= in_opcode;
      width <= in_bit_width;
      count <= in_dice_count;
      if (in_opcode == OP_DICE) begin
        spm1 <= $signed(SPAN_BITS'(in_dice_sides) - SPAN_BITS'(1));
      end else begin
        spm1 <= SPAN_BITS'(in_range_high) - SPAN_BITS'(in_range_low);
      end
    end
    if (cmd.setup) begin
      mask <= mask_setup;
    end
    if (cmd.sum_step) begin
      draw <= sum[WORD_BITS-1:OUT_SHIFT];
    end
    if (cmd.accept) begin
      acc <= acc_accept;
    end else begin
      acc <= acc_next;
    end
    if (cmd.load_out) begin
      out_value <= $signed(acc_next);
    end
  end

  `LFR_ASSERT_IMP(a_lag_gap, clk, rst, 1'b1, (PW'(wp) + PW'(LAG_START) == PW'(lp)) || (PW'(lp) + PW'(TABLE_DEPTH - LAG_START) == PW'(wp)), "lag pointer lost its distance to write pointer")
  `LFR_ASSERT_IMP(a_fill_in_table, clk, rst, 1'b1, fi <= PTR_BITS'(TABLE_DEPTH - 1), "fill index past table end")
  `LFR_ASSERT_IMP(a_draw_owed, clk, rst, cmd.sum_step, left != '0, "table step with no draw owed")

endmodule

`default_nettype wire

[src/lagged_fibonacci_range_rng.sv]
// Lagged Fibonacci generator (lags 55/24); one item in work at a time, read-modify-write of a
// two-read-port table, each table step a sum state then an evaluate state. A range draw repeats
// the step per rejected attempt (rejection), dice per attempt per die; an empty span, 0 or 1
// sides and 0 dice draw nothing, and reseed refills the table. A new item is taken the cycle
// after a result loads.
// Sync active-high reset: seed = 1, then a 55-word table fill during which no item is accepted.
`default_nettype none

module lagged_fibonacci_range_rng #(
  parameter int WORD_BITS = lfr_pkg::WORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  lfr_in_if.sink    req,
  lfr_out_if.source rsp,
  lfr_cfg_if.sink   cfg
);

  import lfr_pkg::*;

  lfr_cmd_t cmd;
  lfr_sts_t sts;

  assign cfg.ready = 1'b1;

  lfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfr_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (req.opcode),
    .in_bit_width  (req.bit_width),
    .in_range_low  (req.range_low),
    .in_range_high (req.range_high),
    .in_dice_count (req.dice_count),
    .in_dice_sides (req.dice_sides),
    .cfg_we        (cfg.valid),
    .cfg_seed      (cfg.seed),
    .out_value     (rsp.value)
  );

endmodule

`default_nettype wire

[sim/lfr_draw_checker.sv]
`default_nettype none

module lfr_draw_checker (
  input  wire logic clk,
  input  wire logic rst,
  lfr_in_if         req,
  lfr_out_if        rsp,
  lfr_cfg_if        cfg,
  output int        mismatches,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int WORD_W    = WORD_BITS_DEF;
  localparam int DRAW_BITS = WORD_W - OUT_SHIFT;

  logic [SEED_BITS-1:0]         seed_reg;
  logic [WORD_W-1:0]            lag_words [TABLE_DEPTH];
  int                           wr_ptr;
  int                           lag_ptr;
  logic signed [VALUE_BITS-1:0] expected_values [$];

  // Fibonacci run from the seed: word 0 = seed, word 1 = 1.
  function automatic void refill_table();
    lag_words[0] = WORD_W'(seed_reg);
    lag_words[1] = WORD_W'(1);
    for (int i = 2; i < TABLE_DEPTH; i++) begin
      lag_words[i] = lag_words[i-1] + lag_words[i-2];
    end
    wr_ptr  = 0;
    lag_ptr = LAG_START;
  endfunction

  function automatic logic [DRAW_BITS-1:0] step_table();
    logic [WORD_W-1:0] total;
    total = lag_words[wr_ptr] + lag_words[lag_ptr];
    lag_words[wr_ptr] = total;
    wr_ptr  = (wr_ptr == TABLE_DEPTH - 1) ? 0 : wr_ptr + 1;
    lag_ptr = (lag_ptr == TABLE_DEPTH - 1) ? 0 : lag_ptr + 1;
    return total[WORD_W-1:OUT_SHIFT];
  endfunction

  // Power-of-two mask with rejection; zero and empty spans draw nothing.
  function automatic longint pick_in_range(input longint lo, input longint hi);
    longint span;
    longint power;
    longint n;
    if (lo == 0 && hi == 0) return 0;
    span = hi - lo + 1;
    if (span <= 1) return lo;
    power = 2;
    while (power < span) power = power << 1;
    do begin
      n = longint'(step_table()) & (power - 1);
    end while (n >= span);
    return lo + n;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] predict_value(
    input logic [OP_BITS-1:0]           op,
    input logic [WIDTH_BITS-1:0]        bw,
    input logic signed [RANGE_BITS-1:0] lo,
    input logic signed [RANGE_BITS-1:0] hi,
    input logic [COUNT_BITS-1:0]        cnt,
    input logic [SIDES_BITS-1:0]        sides
  );
    longint outcome;
    case (op)
      OP_RAW: begin
        outcome = longint'(step_table()) & ((longint'(1) << bw) - 1);
      end
      OP_RANGE: begin
        outcome = pick_in_range(longint'(lo), longint'(hi));
      end
      OP_DICE: begin
        if (sides == 0) begin
          outcome = 0;
        end else if (sides == 1) begin
          outcome = longint'(cnt);
        end else begin
          outcome = 0;
          repeat (cnt) outcome += pick_in_range(1, longint'(sides));
        end
      end
      default: begin
        refill_table();
        outcome = 0;
      end
    endcase
    return outcome[VALUE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [VALUE_BITS-1:0] want;
    if (rst) begin
      seed_reg = SEED_BITS'(SEED_RESET);
      refill_table();
      expected_values.delete();
    end else begin
      if (cfg.valid && cfg.ready) seed_reg = cfg.seed;
      // result leaves before a new item is predicted: it belongs to an older item
      if (rsp.valid && rsp.ready) begin
        if (expected_values.size() == 0) begin
          $error("value: result with no item pending, actual %0d", rsp.value);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          checked++;
          if (rsp.value !== want) begin
            $error("value mismatch: expected %0d, actual %0d", want, rsp.value);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_values.push_back(predict_value(req.opcode, req.bit_width, req.range_low,
                                                req.range_high, req.dice_count,
                                                req.dice_sides));
      end
    end
    pending <= expected_values.size();
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfr_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANGE_MAX       = 8388607;
  localparam int RANGE_MIN       = -8388608;

  logic clk;
  logic rst;

  lfr_in_if  req_if ();
  lfr_out_if rsp_if ();
  lfr_cfg_if cfg_if ();

  int mismatches;
  int pending;
  int checked;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int seed_writes   = 0;
  int op_counts [4];
  int cycle_count   = 0;

  lagged_fibonacci_range_rng dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  lfr_draw_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg        (cfg_if),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic drive_item(
    input logic [OP_BITS-1:0]    op,
    input logic [WIDTH_BITS-1:0] bw,
    input logic [RANGE_BITS-1:0] lo,
    input logic [RANGE_BITS-1:0] hi,
    input logic [COUNT_BITS-1:0] cnt,
    input logic [SIDES_BITS-1:0] sides
  );
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.bit_width  <= bw;
    req_if.range_low  <= lo;
    req_if.range_high <= hi;
    req_if.dice_count <= cnt;
    req_if.dice_sides <= sides;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    op_counts[op]++;
  endtask

  // pending is a registered copy of the checker queue size, hence the first wait
  task automatic wait_idle(input int settle);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_BITS-1:0] v);
    wait_idle(4);
    cfg_if.valid <= 1'b1;
    cfg_if.seed  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    seed_writes++;
    // the new seed only takes effect on reseed
    drive_item(OP_RESEED, WIDTH_BITS'($urandom), RANGE_BITS'($urandom),
               RANGE_BITS'($urandom), COUNT_BITS'($urandom), SIDES_BITS'($urandom));
  endtask

  task automatic run_directed();
    drive_item(OP_RAW,    0,  0, 0, 0, 0);
    drive_item(OP_RAW,    1,  0, 0, 0, 0);
    drive_item(OP_RAW,    24, 0, 0, 0, 0);
    drive_item(OP_RAW,    31, 0, 0, 0, 0);
    drive_item(OP_RANGE,  0, 24'd0, 24'd0, 0, 0);
    drive_item(OP_RANGE,  0, 24'd5, 24'd5, 0, 0);
    drive_item(OP_RANGE,  0, 24'd10, 24'd3, 0, 0);
    drive_item(OP_RANGE,  0, 24'h800000, 24'h7FFFFF, 0, 0);
    drive_item(OP_RANGE,  0, 24'h7FFFFF, 24'h800000, 0, 0);
    drive_item(OP_RANGE,  0, 24'h800000, 24'h800000, 0, 0);
    drive_item(OP_RANGE,  0, 24'd0, 24'd2, 0, 0);
    drive_item(OP_RANGE,  0, -24'sd3, 24'd4, 0, 0);
    drive_item(OP_RANGE,  0, -24'sd1, 24'd0, 0, 0);
    drive_item(OP_DICE,   0, 0, 0, 8'd255, 16'd0);
    drive_item(OP_DICE,   0, 0, 0, 8'd255, 16'd1);
    drive_item(OP_DICE,   0, 0, 0, 8'd0, 16'd1);
    drive_item(OP_DICE,   0, 0, 0, 8'd0, 16'd6);
    drive_item(OP_DICE,   0, 0, 0, 8'd3, 16'd2);
    drive_item(OP_DICE,   0, 0, 0, 8'd10, 16'd6);
    drive_item(OP_DICE,   0, 0, 0, 8'd255, 16'hFFFF);
    drive_item(OP_RESEED, 0, 0, 0, 0, 0);
    drive_item(OP_RAW,    24, 0, 0, 0, 0);
  endtask

  task automatic send_random();
    int                    pick;
    int                    lo;
    int                    hi;
    int                    span;
    logic [OP_BITS-1:0]    op;
    logic [WIDTH_BITS-1:0] bw;
    logic [COUNT_BITS-1:0] cnt;
    logic [SIDES_BITS-1:0] sides;
    pick  = $urandom_range(0, 99);
    bw    = WIDTH_BITS'($urandom);
    cnt   = COUNT_BITS'($urandom);
    sides = SIDES_BITS'($urandom);
    lo    = int'($urandom_range(0, 16777215)) + RANGE_MIN;
    hi    = int'($urandom_range(0, 16777215)) + RANGE_MIN;
    if (pick < 25) begin
      op = OP_RAW;
    end else if (pick < 60) begin
      op = OP_RANGE;
      case ($urandom_range(0, 9))
        0: ;  // random bounds, half of them empty
        1: hi = lo;
        2: begin
          lo = 0;
          hi = 0;
        end
        3: begin
          // one past a power of two: rejection about half the time
          span = (1 << $urandom_range(1, 23)) + 1;
          hi = lo + span - 1;
        end
        default: begin
          span = $urandom_range(1, 1 << $urandom_range(1, 24));
          hi = lo + span - 1;
        end
      endcase
      if (hi > RANGE_MAX) begin
        lo = lo - (hi - RANGE_MAX);
        hi = RANGE_MAX;
      end
    end else if (pick < 94) begin
      op = OP_DICE;
      case ($urandom_range(0, 5))
        0: sides = SIDES_BITS'($urandom);
        1: sides = SIDES_BITS'((1 << $urandom_range(1, 15)) + 1);
        2: sides = SIDES_BITS'($urandom_range(0, 1));
        default: sides = SIDES_BITS'($urandom_range(2, 20));
      endcase
      // big counts are slow, keep them rare
      cnt = COUNT_BITS'(($urandom_range(0, 99) < 3) ? $urandom_range(0, 255) :
                                                      $urandom_range(0, 8));
    end else begin
      op = OP_RESEED;
    end
    drive_item(op, bw, lo[RANGE_BITS-1:0], hi[RANGE_BITS-1:0], cnt, sides);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random();
  endtask

  initial begin
    foreach (op_counts[i]) op_counts[i] = 0;
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_RAW;
    req_if.bit_width  <= '0;
    req_if.range_low  <= '0;
    req_if.range_high <= '0;
    req_if.dice_count <= '0;
    req_if.dice_sides <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.seed       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // seed at its reset value
    run_directed();
    run_random(ITEMS_PER_PHASE);

    write_seed('0);
    send_idle_pct = 58;
    stall_pct     = 0;
    run_random(ITEMS_PER_PHASE);

    write_seed('1);
    send_idle_pct = 0;
    stall_pct     = 58;
    run_random(ITEMS_PER_PHASE);

    write_seed(SEED_BITS'($urandom));
    send_idle_pct = 9;
    stall_pct     = 9;
    run_random(ITEMS_PER_PHASE);

    // long receiver hold-off while items keep coming
    write_seed(SEED_BITS'($urandom));
    send_idle_pct = 0;
    stall_pct     = 30;
    hold_requests++;
    run_random(ITEMS_PER_PHASE);

    wait_idle(60);
    $display("Covered %0d items: %0d raw, %0d range, %0d dice, %0d reseed",
             op_counts[OP_RAW] + op_counts[OP_RANGE] + op_counts[OP_DICE] +
             op_counts[OP_RESEED], op_counts[OP_RAW], op_counts[OP_RANGE],
             op_counts[OP_DICE], op_counts[OP_RESEED]);
    $display("%0d seed writes, %0d results checked, %0d mismatches in %0d cycles",
             seed_writes, checked, mismatches, cycle_count);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
